>>> hdl/cli_pkg.sv
// Shared constants for the circular list block: action and status codes,
// field widths and the default capacity. No dependencies.
package cli_pkg;

  localparam int unsigned CapacityDefault = 32;

  localparam int unsigned ActionW  = 2;
  localparam int unsigned ValueW   = 32;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned EntriesW = 6;

  localparam logic [ActionW-1:0] ActInsFront = 2'd0;
  localparam logic [ActionW-1:0] ActInsBack  = 2'd1;
  localparam logic [ActionW-1:0] ActRemove   = 2'd2;
  localparam logic [ActionW-1:0] ActDump     = 2'd3;

  localparam logic [StatusW-1:0] StDone     = 3'd0;
  localparam logic [StatusW-1:0] StFull     = 3'd1;
  localparam logic [StatusW-1:0] StEmpty    = 3'd2;
  localparam logic [StatusW-1:0] StNotFound = 3'd3;
  localparam logic [StatusW-1:0] StElement  = 3'd4;

endpackage

>>> hdl/circular_list_insert_remove.sv
// Top level of the bounded circular list: sequencer, head/count registers,
// output register. Depends on cli_pkg and cli_ram.
//
// Usage: one input beat (action, value) per item on a valid/ready channel.
// Inserts, removals and failed operations give one result beat; a dump of
// a non-empty list gives one beat per entry from the head, last_o set on
// the final one. Every result carries the entry count after the item.
// Timing: an insert passes through the response state to the output
// register. A removal searches one entry per cycle from the head, then
// shifts the tail down one entry per cycle through the single read and
// write port of the entry store, then passes through the response state.
// A dump reads the head, then gives one beat per cycle while not stalled.
// The next item is taken once the final result sits in the output register.
// Reset clears head, count, state and the output valid; the entry store
// needs no clearing, only written entries are ever read.
// A stalled receiver holds the output register; a dump simply pauses.
module circular_list_insert_remove #(
  parameter int unsigned CAPACITY = cli_pkg::CapacityDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [cli_pkg::ActionW-1:0]      action_i,
  input  logic signed [cli_pkg::ValueW-1:0] value_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [cli_pkg::StatusW-1:0]      status_o,
  output logic signed [cli_pkg::ValueW-1:0] element_o,
  output logic [cli_pkg::EntriesW-1:0]     entries_o,
  output logic                             last_o
);
  import cli_pkg::*;

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SRCH  = 3'd1;
  localparam logic [2:0] S_SHIFT = 3'd2;
  localparam logic [2:0] S_DUMP  = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  function automatic logic [IW-1:0] slot(input logic [IW-1:0] h, input logic [CW-1:0] off);
    logic [CW:0] s;
    s = {{(CW + 1 - IW){1'b0}}, h} + {1'b0, off};
    if (s >= (CW + 1)'(CAPACITY)) begin
      s = s - (CW + 1)'(CAPACITY);
    end
    return s[IW-1:0];
  endfunction

  logic [2:0]         state_q, state_d;
  logic [IW-1:0]      head_q, head_d;
  logic [CW-1:0]      count_q, count_d;
  logic [CW-1:0]      idx_q, idx_d;
  logic [ValueW-1:0]  val_q, val_d;
  logic [StatusW-1:0] resp_q, resp_d;

  logic               out_valid_q, out_valid_d;
  logic [StatusW-1:0] status_q, status_d;
  logic [ValueW-1:0]  element_q, element_d;
  logic               last_q, last_d;
  logic [CW-1:0]      ent_q, ent_d;

  logic               we, re;
  logic [IW-1:0]      waddr, raddr;
  logic [ValueW-1:0]  wdata, rdata;

  logic               out_free, accept;
  logic [CW-1:0]      nxt, nxt2;
  logic [CW+5:0]      ent_ext;

  cli_ram #(
    .Depth(CAPACITY),
    .Width(ValueW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign out_free = !out_valid_q || out_ready_i;
  assign accept   = in_valid_i && in_ready_o;
  assign nxt      = idx_q + CW'(1);
  assign nxt2     = idx_q + CW'(2);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    idx_d       = idx_q;
    val_d       = val_q;
    resp_d      = resp_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    element_d   = element_q;
    last_d      = last_q;
    ent_d       = ent_q;
    we          = 1'b0;
    waddr       = slot(head_q, idx_q);
    wdata       = rdata;
    re          = 1'b0;
    raddr       = slot(head_q, nxt);

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          val_d   = value_i;
          idx_d   = '0;
          state_d = S_RESP;
          unique case (action_i) inside
            ActInsFront, ActInsBack: begin
              if (count_q >= CW'(CAPACITY)) begin
                resp_d = StFull;
              end else begin
                resp_d  = StDone;
                count_d = count_q + CW'(1);
                we      = 1'b1;
                wdata   = value_i;
                if (action_i == ActInsFront) begin
                  head_d = (head_q == '0) ? IW'(CAPACITY - 1) : head_q - IW'(1);
                  waddr  = head_d;
                end else begin
                  waddr = slot(head_q, count_q);
                end
              end
            end
            default: begin
              if (count_q == '0) begin
                resp_d = StEmpty;
              end else begin
                re      = 1'b1;
                raddr   = head_q;
                state_d = (action_i == ActDump) ? S_DUMP : S_SRCH;
              end
            end
          endcase
        end
      end

      // rdata holds the entry at offset idx_q
      S_SRCH: begin
        if (rdata == val_q) begin
          resp_d  = StDone;
          count_d = count_q - CW'(1);
          if (idx_q == '0) begin
            head_d  = slot(head_q, CW'(1));
            state_d = S_RESP;
          end else if (nxt == count_q) begin
            state_d = S_RESP;
          end else begin
            re      = 1'b1;
            raddr   = slot(head_q, nxt);
            state_d = S_SHIFT;
          end
        end else if (nxt == count_q) begin
          resp_d  = StNotFound;
          state_d = S_RESP;
        end else begin
          re    = 1'b1;
          raddr = slot(head_q, nxt);
          idx_d = nxt;
        end
      end

      // rdata holds offset idx_q+1; move it down to idx_q. count_q is
      // already decremented, so the tail is reached when idx_q+1 == count_q.
      S_SHIFT: begin
        we    = 1'b1;
        waddr = slot(head_q, idx_q);
        wdata = rdata;
        if (nxt == count_q) begin
          state_d = S_RESP;
        end else begin
          re    = 1'b1;
          raddr = slot(head_q, nxt2);
          idx_d = nxt;
        end
      end

      S_DUMP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = StElement;
          element_d   = rdata;
          ent_d       = count_q;
          last_d      = (nxt == count_q);
          if (nxt == count_q) begin
            state_d = S_IDLE;
          end else begin
            re    = 1'b1;
            raddr = slot(head_q, nxt);
            idx_d = nxt;
          end
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = resp_q;
          element_d   = '0;
          ent_d       = count_q;
          last_d      = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    val_q     <= val_d;
    resp_q    <= resp_d;
    status_q  <= status_d;
    element_q <= element_d;
    last_q    <= last_d;
    ent_q     <= ent_d;
  end

  assign ent_ext     = {6'b0, ent_q};
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign element_o   = element_q;
  assign entries_o   = ent_ext[5:0];
  assign last_o      = last_q;

endmodule

>>> hdl/cli_ram.sv
// Entry store of the circular list: one write port, one read port,
// registered read data that holds while no read is issued. No dependencies.
module cli_ram #(
  parameter int unsigned Depth = 32,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
